// ----- hw/rtl/sba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// Shared widths, operation codes and defaults of the sector bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

	// Default map size in sectors
	localparam int MAP_BITS_DEF = 2048;

	// Bitmap word geometry: one memory word holds 64 sector bits
	localparam int WORD_W  = 64;
	localparam int WORD_SH = 6;

	// Port field widths
	localparam int OP_W      = 2;
	localparam int SEC_W     = 11;
	localparam int CNT_OUT_W = 12;

	// Width used for global sector index compares (holds up to 8191)
	localparam int GIDX_W = 13;

	// Operation codes
	localparam logic [OP_W-1:0] OP_FIND      = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK_USED = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;

endpackage

// ----- hw/rtl/sba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sba_ram #(
	parameter int W = 64,
	parameter int D = 32
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                 wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                 rdata
);

	logic [W-1:0] mem [D];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/sector_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_bitmap_allocator_top
// One-bit-per-sector allocation bitmap held in a 64-bit-wide RAM, with a
// running free count. Finds the lowest free sector from a start index, or
// marks a single sector used or free.
// ----------------------------------------------------------------------------
// Sequence: a mark reads its word on accept and writes it back in S_SCAN; a
//   find scans words from the start word in S_SCAN until a free bit or the
//   last word (up to MAP_BITS/64 words, 32 by default); a bad index or code
//   goes straight to S_DONE. S_DONE passes the result to the output register
//   once that is free. One item at a time: in_stall stays high until then.
// Reset: per-word valid flops clear at once, so the whole map reads free
//   right after reset; free count resets to MAP_BITS. No clearing pass.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator_top
	import sba_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [SEC_W-1:0]     sector,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic [SEC_W-1:0]     found_sector,
	output logic [CNT_OUT_W-1:0] free_count
);

	localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W = $clog2(MAP_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [SEC_W-1:0]  sec_q;
	logic [AW-1:0]     addr_q;
	logic [WORDS-1:0]  wvalid_q;
	logic [CNT_W-1:0]  free_q;
	logic              res_ok_q;
	logic [SEC_W-1:0]  res_found_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [SEC_W-1:0]  found_q;
	logic [CNT_OUT_W-1:0] count_q;

	logic              in_acc;
	logic              in_legal;
	logic              out_free;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] free_vec;
	logic              hit;
	logic [WORD_SH-1:0] hit_pos;
	logic [GIDX_W-1:0] hit_gidx;
	logic              cur_bit;
	logic              want_used;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Input check: known code and sector inside the map
	assign in_legal = (operation inside {OP_FIND, OP_MARK_USED, OP_MARK_FREE}) &&
		(GIDX_W'(sector) < GIDX_W'(MAP_BITS));

	// Read address: start word on accept, next word while scanning
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = AW'(sector >> WORD_SH);
		end else begin
			rd_addr = AW'(addr_q + AW'(1));
		end
	end

	sba_ram #(
		.W(WORD_W),
		.D(WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Word never written since reset reads as all free
	assign word = wvalid_q[addr_q] ? rd_data : '0;

	// Free bits at or above the start and inside the map
	always_comb begin
		logic [GIDX_W-1:0] gidx;
		for (int j = 0; j < WORD_W; j++) begin
			gidx = (GIDX_W'(addr_q) << WORD_SH) | GIDX_W'(j);
			free_vec[j] = !word[j] && (gidx >= GIDX_W'(sec_q)) &&
				(gidx < GIDX_W'(MAP_BITS));
		end
	end

	// Lowest free bit of the current word
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				hit     = 1'b1;
				hit_pos = WORD_SH'(j);
			end
		end
	end
	assign hit_gidx = (GIDX_W'(addr_q) << WORD_SH) | GIDX_W'(hit_pos);

	// Mark path: modify one bit of the word and write it back
	assign cur_bit   = word[sec_q[WORD_SH-1:0]];
	assign want_used = (op_q == OP_MARK_USED);
	assign ram_we    = (state_q == S_SCAN) && (op_q != OP_FIND) && (cur_bit != want_used);
	always_comb begin
		ram_wdata = word;
		ram_wdata[sec_q[WORD_SH-1:0]] = want_used;
	end

	// Control sequencer, free count and word valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wvalid_q <= '0;
			free_q   <= CNT_W'(MAP_BITS);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= in_legal ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (op_q == OP_FIND) begin
						if (hit || (32'(addr_q) == WORDS - 1)) begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_DONE;
						if (ram_we) begin
							wvalid_q[addr_q] <= 1'b1;
							if (want_used) begin
								free_q <= free_q - CNT_W'(1);
							end else begin
								free_q <= free_q + CNT_W'(1);
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields, word pointer and pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q        <= operation;
			sec_q       <= sector;
			addr_q      <= AW'(sector >> WORD_SH);
			res_ok_q    <= 1'b0;
			res_found_q <= '0;
		end else if (state_q == S_SCAN) begin
			addr_q <= AW'(addr_q + AW'(1));
			if (op_q == OP_FIND) begin
				if (hit) begin
					res_ok_q    <= 1'b1;
					res_found_q <= hit_gidx[SEC_W-1:0];
				end
			end else begin
				res_ok_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			ok_q    <= res_ok_q;
			found_q <= res_found_q;
			count_q <= CNT_OUT_W'(free_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign found_sector = found_q;
	assign free_count   = count_q;

endmodule

// ----- tb/sv/tb_sector_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_bitmap_allocator_top
// Self-checking bench for the sector bitmap allocator. A shadow copy of the
// allocation map and free count predicts every reply. A directed opening
// covers the map edges, redundant marks, a search that finds nothing and the
// unused operation code. Random rounds then fill runs of sectors, release
// parts of them and mix searches and marks, with random gaps on the request
// side and random stalls on the reply side.
// ----------------------------------------------------------------------------
module tb_sector_bitmap_allocator_top;
	import sba_pkg::*;

	localparam int MAP_BITS     = MAP_BITS_DEF;
	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 80;

	// operation code the block does not define
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [SEC_W-1:0]     sec;
		logic                 ok;
		logic [SEC_W-1:0]     found;
		logic [CNT_OUT_W-1:0] count;
	} sector_reply_t;

	// Shadow allocation map and queue of replies still owed by the block
	class sector_map_tracker;
		bit            used_map [MAP_BITS];
		int            free_total;
		sector_reply_t owed [$];
		int n_find, n_miss, n_mark, n_redundant, n_unused;
		int n_checked, n_bad, min_free;

		function new();
			foreach (used_map[i]) used_map[i] = 1'b0;
			free_total = MAP_BITS;
			min_free   = MAP_BITS;
		endfunction

		// Apply one accepted item to the shadow map and queue its reply
		function void note_request(logic [OP_W-1:0] op, logic [SEC_W-1:0] sec);
			sector_reply_t r;
			bit want;
			r.op    = op;
			r.sec   = sec;
			r.ok    = 1'b0;
			r.found = '0;
			if (op == OP_FIND) begin
				n_find++;
				if (int'(sec) < MAP_BITS) begin
					for (int i = int'(sec); i < MAP_BITS; i++) begin
						if (!used_map[i]) begin
							r.ok    = 1'b1;
							r.found = SEC_W'(i);
							break;
						end
					end
				end
				if (!r.ok) n_miss++;
			end else if (op == OP_MARK_USED || op == OP_MARK_FREE) begin
				n_mark++;
				if (int'(sec) < MAP_BITS) begin
					want = (op == OP_MARK_USED);
					if (used_map[sec] != want) begin
						used_map[sec] = want;
						free_total += want ? -1 : 1;
					end else begin
						n_redundant++;
					end
					r.ok = 1'b1;
				end
			end else begin
				n_unused++;
			end
			if (free_total < min_free) min_free = free_total;
			r.count = CNT_OUT_W'(free_total);
			owed.push_back(r);
		endfunction

		// Compare one accepted reply against the oldest owed one
		function void check_reply(logic ok_a, logic [SEC_W-1:0] found_a,
				logic [CNT_OUT_W-1:0] count_a);
			sector_reply_t r;
			if (owed.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: reply with none owed: ok=%0b found=%0d count=%0d",
						$realtime, ok_a, found_a, count_a);
				return;
			end
			r = owed.pop_front();
			n_checked++;
			if (ok_a !== r.ok || found_a !== r.found || count_a !== r.count) begin
				n_bad++;
				if (n_bad <= 10)
					$display({"%0t: op=%0d sector=%0d mismatch: ok exp %0b got %0b, ",
						"found exp %0d got %0d, count exp %0d got %0d"},
						$realtime, r.op, r.sec, r.ok, ok_a, r.found, found_a,
						r.count, count_a);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Anything still owed at the end is a failure
		function void close_out();
			if (owed.size() != 0) begin
				n_bad += owed.size();
				$display("%0d replies never arrived", owed.size());
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      operation;
	logic [SEC_W-1:0]     sector;
	logic                 out_valid;
	logic                 out_stall;
	logic                 ok;
	logic [SEC_W-1:0]     found_sector;
	logic [CNT_OUT_W-1:0] free_count;

	sector_map_tracker alloc_map = new();
	int n_sent;
	int idle_cycles;

	sector_bitmap_allocator_top #(
		.MAP_BITS(MAP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.sector(sector),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.found_sector(found_sector),
		.free_count(free_count)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Send one item after a random gap, then wait for it to be taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SEC_W-1:0] sec);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			gap = 0;
		else if (pick < 95)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 30);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		sector    <= sec;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		alloc_map.note_request(op, sec);
		n_sent++;
	endtask

	// Reply-side stall: quiet stretches, short stalls and a few long ones
	initial begin
		int hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 9) < 2) begin
				out_stall <= 1'b0;
				hold = $urandom_range(20, 100);
			end else if ($urandom_range(0, 1) == 0) begin
				out_stall <= 1'b1;
				hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
				hold = $urandom_range(0, 3);
			end
		end
	end

	// Reply checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			alloc_map.check_reply(ok, found_sector, free_count);
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("tb_sector_bitmap_allocator_top: FAIL");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int round;
		int base;
		int len;
		int pick;
		logic [OP_W-1:0]  op_r;
		logic [SEC_W-1:0] sec_r;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_FIND;
		sector      = '0;
		n_sent      = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: map edges, redundant marks, empty search, unused code
		send_item(OP_FIND, 11'd0);
		send_item(OP_FIND, 11'd2047);
		send_item(OP_MARK_USED, 11'd0);
		send_item(OP_MARK_USED, 11'd0);
		send_item(OP_MARK_FREE, 11'd5);
		send_item(OP_FIND, 11'd0);
		send_item(OP_MARK_USED, 11'd2047);
		send_item(OP_FIND, 11'd2047);
		send_item(OP_UNUSED, 11'd2047);
		send_item(OP_UNUSED, 11'd0);
		for (int s = 2040; s < 2047; s++)
			send_item(OP_MARK_USED, SEC_W'(s));
		send_item(OP_FIND, 11'd2040);
		send_item(OP_FIND, 11'd1985);
		send_item(OP_MARK_FREE, 11'd2047);
		send_item(OP_FIND, 11'd2040);
		send_item(OP_MARK_FREE, 11'd0);
		send_item(OP_MARK_USED, 11'h555);
		send_item(OP_MARK_USED, 11'h2aa);

		// Random rounds
		round = 0;
		while (n_sent < 24 + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			base = ($urandom_range(0, 1) == 0) ? $urandom_range(1800, MAP_BITS - 1)
				: $urandom_range(0, MAP_BITS - 1);
			if (pick < 3) begin
				// fill a run of sectors, then search from its start
				len = $urandom_range(8, 140);
				for (int s = base; s < base + len && s < MAP_BITS; s++)
					send_item(OP_MARK_USED, SEC_W'(s));
				send_item(OP_FIND, SEC_W'(base));
				if ($urandom_range(0, 2) == 0)
					send_item(OP_FIND, 11'd0);
			end else if (pick < 5) begin
				// release scattered sectors near the base, then search
				len = $urandom_range(5, 30);
				for (int k = 0; k < len; k++)
					send_item(OP_MARK_FREE,
						SEC_W'((base + $urandom_range(0, 255)) % MAP_BITS));
				send_item(OP_FIND, SEC_W'(base));
			end else begin
				// mixed traffic, hot window or anywhere; pick 9 is plain noise
				for (int k = 0; k < 20; k++) begin
					len = $urandom_range(0, 99);
					if (pick == 9)
						op_r = OP_W'($urandom_range(0, 3));
					else if (len < 40)
						op_r = OP_FIND;
					else if (len < 70)
						op_r = OP_MARK_USED;
					else if (len < 95)
						op_r = OP_MARK_FREE;
					else
						op_r = OP_UNUSED;
					len = $urandom_range(0, 9);
					if (pick == 9 || len < 4)
						sec_r = SEC_W'($urandom_range(0, MAP_BITS - 1));
					else if (len == 4)
						sec_r = '0;
					else
						sec_r = SEC_W'((base + $urandom_range(0, 127)) % MAP_BITS);
					send_item(op_r, sec_r);
				end
			end
			round++;
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain
		while (alloc_map.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		alloc_map.close_out();

		$display("%0d items in %0d random rounds: %0d searches (%0d found nothing), %0d marks",
			n_sent, round, alloc_map.n_find, alloc_map.n_miss, alloc_map.n_mark);
		$display("%0d redundant marks, %0d unused codes, lowest free count %0d, %0d replies checked",
			alloc_map.n_redundant, alloc_map.n_unused, alloc_map.min_free,
			alloc_map.n_checked);
		if (alloc_map.n_bad == 0) begin
			$display("tb_sector_bitmap_allocator_top: PASS");
		end else begin
			$display("%0d failures", alloc_map.n_bad);
			$display("tb_sector_bitmap_allocator_top: FAIL");
		end
		$finish;
	end

endmodule
